// ===== hdl/fral_pkg.sv =====
// Shared constants, types and sequencer states for the settings append log.
package fral_pkg;

	localparam int unsigned SLOTS = 2048;
	localparam int unsigned SLOT_W = $clog2(SLOTS);
	localparam int unsigned CNT_W = $clog2(SLOTS + 1);
	localparam int unsigned WORD_W = 32;
	localparam logic [WORD_W-1:0] ERASED_WORD = {WORD_W{1'b1}};
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	// action codes
	localparam logic ACT_READ = 1'b0;
	localparam logic ACT_APPEND = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_ISSUE,
		ST_SRCH_CMP,
		ST_LOC_CHK,
		ST_RD_ISSUE,
		ST_RD_DATA,
		ST_APPEND,
		ST_DONE
	} state_t;

	// request from the sequencer to the slot store
	typedef struct packed {
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
		logic              clear;
	} store_req_t;

endpackage

// ===== hdl/flash_record_append_log_top.sv =====
// Settings append log: sequencer, binary search and output register.
//
// Keeps one 32-bit settings word in a store of 2048 slots, appending each new
// word to the next slot. Input words (action, write_value) arrive on a
// valid/stall channel; one result word (record_value, sector_erased) leaves on
// a valid/stall channel for every input word.
// The first access after reset locates the newest slot by a binary search:
// one memory read and one compare per step, eleven steps, then a read and
// check of slot 0. An empty store gets default_record programmed into slot 0
// there. After a read is accepted, the word passes through the registered
// memory read (ST_RD_ISSUE, ST_RD_DATA) into the output register in ST_DONE;
// an append goes through ST_APPEND and ST_DONE; on the first access both
// follow the search. The next word is accepted the cycle after the result
// is loaded. An append past the last slot erases the whole store (fill
// count reset) and flags sector_erased. in_stall stays high while busy and
// while the result waits for an output register held by a stalled receiver.
// Reset clears the fill count (all slots erased), the located flag and
// default_record; default_record is written through cfg_wr_en / cfg_wr_data,
// which the user must do only while idle; the block does not enforce it.
module flash_record_append_log_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [fral_pkg::WORD_W-1:0]     cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic [fral_pkg::WORD_W-1:0]     write_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [fral_pkg::WORD_W-1:0]     record_value,
	output logic                            sector_erased
);

	fral_pkg::state_t             state_q, state_d;
	fral_pkg::store_req_t         req;
	logic [fral_pkg::WORD_W-1:0]  rd_data;

	logic [fral_pkg::WORD_W-1:0]  default_q;
	logic                         action_q;
	logic [fral_pkg::WORD_W-1:0]  value_q;
	logic                         known_q;
	logic [fral_pkg::SLOT_W-1:0]  cur_q;
	logic [fral_pkg::SLOT_W-1:0]  lo_q;
	logic [fral_pkg::SLOT_W:0]    hi_q;
	logic [fral_pkg::WORD_W-1:0]  res_q;
	logic                         res_erased_q;
	logic                         out_valid_q;
	logic [fral_pkg::WORD_W-1:0]  out_value_q;
	logic                         out_erased_q;

	logic                         in_accept;
	logic                         out_free;
	logic [fral_pkg::SLOT_W:0]    mid_sum;
	logic [fral_pkg::SLOT_W-1:0]  mid;
	logic                         srch_more;
	logic                         wrap;

	// control outputs
	logic                         ld_search;
	logic                         ld_cmp;
	logic                         ld_locate;
	logic                         ld_read_res;
	logic                         ld_append;
	logic                         ld_out;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign mid_sum   = {1'b0, lo_q} + hi_q;
	assign mid       = mid_sum[fral_pkg::SLOT_W:1];
	assign srch_more = ({1'b0, lo_q} + (fral_pkg::SLOT_W+1)'(1)) < hi_q;
	assign wrap      = (cur_q == fral_pkg::LAST_SLOT);

	fral_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fral_pkg::ST_IDLE: begin
				if (in_accept) begin
					if (!known_q) begin
						state_d = fral_pkg::ST_SRCH_ISSUE;
					end else if (action == fral_pkg::ACT_APPEND) begin
						state_d = fral_pkg::ST_APPEND;
					end else begin
						state_d = fral_pkg::ST_RD_ISSUE;
					end
				end
			end
			fral_pkg::ST_SRCH_ISSUE: begin
				state_d = srch_more ? fral_pkg::ST_SRCH_CMP : fral_pkg::ST_LOC_CHK;
			end
			fral_pkg::ST_SRCH_CMP: state_d = fral_pkg::ST_SRCH_ISSUE;
			fral_pkg::ST_LOC_CHK: begin
				state_d = (action_q == fral_pkg::ACT_APPEND) ? fral_pkg::ST_APPEND
				                                             : fral_pkg::ST_RD_ISSUE;
			end
			fral_pkg::ST_RD_ISSUE: state_d = fral_pkg::ST_RD_DATA;
			fral_pkg::ST_RD_DATA:  state_d = fral_pkg::ST_DONE;
			fral_pkg::ST_APPEND:   state_d = fral_pkg::ST_DONE;
			fral_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = fral_pkg::ST_IDLE;
				end
			end
			default: state_d = fral_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs and store requests
	always_comb begin
		in_stall    = 1'b1;
		ld_search   = 1'b0;
		ld_cmp      = 1'b0;
		ld_locate   = 1'b0;
		ld_read_res = 1'b0;
		ld_append   = 1'b0;
		ld_out      = 1'b0;
		req.rd_addr = cur_q;
		req.wr_en   = 1'b0;
		req.wr_addr = cur_q;
		req.wr_data = value_q;
		req.clear   = 1'b0;
		case (state_q)
			fral_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				ld_search = 1'b1;
			end
			fral_pkg::ST_SRCH_ISSUE: begin
				// after the last step, fetch slot 0 for the empty-store check
				req.rd_addr = srch_more ? mid : '0;
			end
			fral_pkg::ST_SRCH_CMP: begin
				ld_cmp = 1'b1;
			end
			fral_pkg::ST_LOC_CHK: begin
				ld_locate = 1'b1;
				if (lo_q == '0 && rd_data == fral_pkg::ERASED_WORD) begin
					req.wr_en   = 1'b1;
					req.wr_addr = '0;
					req.wr_data = default_q;
				end
			end
			fral_pkg::ST_RD_ISSUE: begin
				req.rd_addr = cur_q;
			end
			fral_pkg::ST_RD_DATA: begin
				ld_read_res = 1'b1;
			end
			fral_pkg::ST_APPEND: begin
				ld_append   = 1'b1;
				req.wr_en   = 1'b1;
				req.clear   = wrap;
				req.wr_addr = wrap ? '0 : cur_q + fral_pkg::SLOT_W'(1);
			end
			fral_pkg::ST_DONE: begin
				ld_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fral_pkg::ST_IDLE;
			known_q     <= 1'b0;
			cur_q       <= '0;
			default_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				default_q <= cfg_wr_data;
			end
			if (ld_locate) begin
				known_q <= 1'b1;
				cur_q   <= lo_q;
			end
			if (ld_append) begin
				cur_q <= wrap ? '0 : cur_q + fral_pkg::SLOT_W'(1);
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// input word, search bounds and result words
	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_q <= action;
			value_q  <= write_value;
		end
		if (ld_search) begin
			lo_q <= '0;
			hi_q <= (fral_pkg::SLOT_W+1)'(fral_pkg::SLOTS);
		end
		// one compare per step: a programmed slot moves the low bound up
		if (ld_cmp) begin
			if (rd_data != fral_pkg::ERASED_WORD) begin
				lo_q <= mid;
			end else begin
				hi_q <= {1'b0, mid};
			end
		end
		if (ld_read_res) begin
			res_q        <= rd_data;
			res_erased_q <= 1'b0;
		end
		if (ld_append) begin
			res_q        <= value_q;
			res_erased_q <= wrap;
		end
		if (ld_out) begin
			out_value_q  <= res_q;
			out_erased_q <= res_erased_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign record_value  = out_value_q;
	assign sector_erased = out_erased_q;

endmodule

// ===== hdl/fral_store.sv =====
// Slot store: word memory with a fill count standing in for the erased state.
module fral_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fral_pkg::store_req_t                req,
	output logic [fral_pkg::WORD_W-1:0]         rd_data
);

	logic [fral_pkg::WORD_W-1:0] mem [fral_pkg::SLOTS];
	logic [fral_pkg::WORD_W-1:0] mem_rd_q;
	logic                        rd_valid_q;
	logic [fral_pkg::CNT_W-1:0]  fill_q;
	logic [fral_pkg::CNT_W-1:0]  fill_d;

	// programmed slots are always 0 .. fill_q-1; erase just drops the count
	always_comb begin
		fill_d = fill_q;
		if (req.clear) begin
			fill_d = '0;
		end
		if (req.wr_en) begin
			fill_d = fral_pkg::CNT_W'(req.wr_addr) + fral_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			fill_q     <= fill_d;
			rd_valid_q <= (fral_pkg::CNT_W'(req.rd_addr) < fill_q);
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		mem_rd_q <= mem[req.rd_addr];
	end

	// a slot past the fill count reads as erased
	assign rd_data = rd_valid_q ? mem_rd_q : fral_pkg::ERASED_WORD;

endmodule
